FILE: rtl/core/bra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and constants for the bitmap run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int MaxBytes  = 512;
    localparam int AddrW     = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;
    localparam int NByW      = $clog2(MaxBytes + 1);
    localparam int NBitsW    = NByW + 3;
    localparam int MapBytesW = 10;
    localparam int BitIdxW   = 12;
    localparam int RunLenW   = 13;
    localparam int SumW      = ((AddrW + 3) > RunLenW) ? (AddrW + 3) : RunLenW;

    typedef enum logic [1:0] {
        FN_CLEAR = 2'd0,
        FN_TEST  = 2'd1,
        FN_SCAN  = 2'd2,
        FN_SET   = 2'd3
    } t_func;

    typedef struct packed {
        t_func                func;
        logic [BitIdxW-1:0]   bit_index;
        logic [RunLenW-1:0]   run_length;
        logic                 bit_value;
    } t_bra_in;

    typedef struct packed {
        logic                 found;
        logic [BitIdxW-1:0]   start_index;
        logic                 bit_read;
    } t_bra_out;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RD,
        ST_MOD,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic en;
    } t_run_ctl;

    typedef struct packed {
        logic               hit;
        logic [BitIdxW-1:0] start;
    } t_run_res;

endpackage
`default_nettype wire

FILE: rtl/core/bitmap_run_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_run_allocator_unit
// Bit-per-unit allocation map with clear, test, set and first-fit run scan.
// ----------------------------------------------------------------------------
// One item is handled at a time; the map lives in a byte-wide memory with a
// single read port, and that port sets the pace. Test and set pass through
// a read state and a modify state before the result. Clear writes one byte
// a cycle over the bytes in use. Scan reads one byte a cycle until the run
// is found or the last byte in use is done. Out-of-range requests go straight
// to the done state. After reset the whole map is swept to zero, one byte a
// cycle, before the first item is taken; the map-size register may be
// written meanwhile.
// A finished result waits in an output register while the next item starts.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_unit
    import bra_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_bra_in              i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_bra_out                  o_out_item,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [MapBytesW-1:0] i_cfg_wr_data
);

    t_state                r_state;
    t_state                n_state;
    t_bra_in               r_item;
    t_bra_in               n_item;
    logic [NByW-1:0]       r_addr;
    logic [NByW-1:0]       n_addr;
    logic                  r_dv;
    logic                  n_dv;
    logic [AddrW-1:0]      r_dbyte;
    t_bra_out              r_res;
    t_bra_out              n_res;
    t_bra_out              r_out;
    logic                  r_out_valid;
    logic [MapBytesW-1:0]  r_map_bytes;

    logic [NByW-1:0]       w_nbytes;
    logic [NBitsW-1:0]     w_nbits;
    logic                  w_accept;
    logic                  w_idx_ok;
    logic                  w_len_ok;
    logic                  w_clr_last;
    logic                  w_scan_last;
    logic                  w_out_load;
    logic                  w_scan_end;

    logic                  w_rd_en;
    logic [AddrW-1:0]      w_rd_addr;
    logic [7:0]            w_rd_data;
    logic                  w_wr_en;
    logic [AddrW-1:0]      w_wr_addr;
    logic [7:0]            w_wr_data;
    logic [7:0]            w_mask;
    t_run_ctl              w_run_ctl;
    t_run_res              w_run_res;

    // ---- map size and request checks ----
    assign w_nbytes = (int'(r_map_bytes) > MaxBytes) ? NByW'(MaxBytes) : NByW'(r_map_bytes);
    assign w_nbits  = {w_nbytes, 3'b000};

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_idx_ok    = NBitsW'(i_in_item.bit_index) < w_nbits;
    assign w_len_ok    = (i_in_item.run_length != '0)
                      && (NBitsW'(i_in_item.run_length) <= w_nbits);
    assign w_clr_last  = (r_addr == (w_nbytes - 1'b1));
    assign w_scan_last = (NByW'(r_dbyte) == (w_nbytes - 1'b1));
    assign w_scan_end  = r_dv && (w_run_res.hit || w_scan_last);
    assign w_out_load  = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign w_mask      = 8'(1) << r_item.bit_index[2:0];

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_addr == NByW'(MaxBytes - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_item.func)
                        FN_CLEAR: n_state = (w_nbytes == '0) ? ST_DONE : ST_CLEAR;
                        FN_TEST,
                        FN_SET:   n_state = w_idx_ok ? ST_RD : ST_DONE;
                        FN_SCAN:  n_state = w_len_ok ? ST_SCAN : ST_DONE;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_RD:   n_state = ST_MOD;
            ST_MOD:  n_state = ST_DONE;
            ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    // ---- state outputs ----
    always_comb begin
        o_in_ready    = 1'b0;
        n_item        = r_item;
        n_addr        = r_addr;
        n_dv          = 1'b0;
        n_res         = r_res;
        w_rd_en       = 1'b0;
        w_rd_addr     = r_addr[AddrW-1:0];
        w_wr_en       = 1'b0;
        w_wr_addr     = r_addr[AddrW-1:0];
        w_wr_data     = '0;
        w_run_ctl.clr = 1'b0;
        w_run_ctl.en  = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                w_wr_en = 1'b1;
                n_addr  = r_addr + 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    n_item        = i_in_item;
                    n_addr        = '0;
                    n_res         = '0;
                    w_run_ctl.clr = 1'b1;
                    if (i_in_item.func == FN_CLEAR) begin
                        n_res.found = 1'b1;
                    end
                end
            end
            ST_CLEAR: begin
                w_wr_en = 1'b1;
                n_addr  = r_addr + 1'b1;
            end
            ST_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = AddrW'(r_item.bit_index >> 3);
            end
            ST_MOD: begin
                n_res.found = 1'b1;
                w_wr_addr   = AddrW'(r_item.bit_index >> 3);
                if (r_item.func == FN_TEST) begin
                    n_res.bit_read = w_rd_data[r_item.bit_index[2:0]];
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_data = r_item.bit_value ? (w_rd_data | w_mask)
                                                 : (w_rd_data & ~w_mask);
                end
            end
            ST_SCAN: begin
                // keep the read port streaming; the run counter takes each byte as it leaves the registered read port
                if (r_addr < w_nbytes) begin
                    w_rd_en = 1'b1;
                    n_dv    = 1'b1;
                    n_addr  = r_addr + 1'b1;
                end
                w_run_ctl.en = r_dv;
                if (w_scan_end) begin
                    n_res.found       = w_run_res.hit;
                    n_res.start_index = w_run_res.hit ? w_run_res.start : '0;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_map_bytes <= MapBytesW'(MaxBytes);
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_dv    <= n_dv;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_map_bytes <= i_cfg_wr_data;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_res   <= n_res;
        r_dbyte <= r_addr[AddrW-1:0];
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    bra_mem u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    bra_run u_run (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_run_ctl),
        .i_data  (w_rd_data),
        .i_byte  (r_dbyte),
        .i_len   (r_item.run_length),
        .o_res   (w_run_res)
    );

endmodule
`default_nettype wire

FILE: rtl/core/bra_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bra_mem
// Allocation map storage: one byte per entry, one write and one registered
// read port.
// ----------------------------------------------------------------------------
module bra_mem
    import bra_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AddrW-1:0] i_rd_addr,
    output logic [7:0]            o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [AddrW-1:0] i_wr_addr,
    input  wire logic [7:0]       i_wr_data
);

    logic [7:0] r_mem [MaxBytes];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: rtl/core/bra_run.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bra_run
// Free-run counter: while enabled, consumes one map byte per cycle, LSB first,
// and flags the first bit at which the run of zero bits reaches the wanted length.
// ----------------------------------------------------------------------------
module bra_run
    import bra_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_run_ctl           i_ctl,
    input  wire logic [7:0]         i_data,
    input  wire logic [AddrW-1:0]   i_byte,
    input  wire logic [RunLenW-1:0] i_len,
    output t_run_res                o_res
);

    logic [RunLenW-1:0] r_count;
    logic [RunLenW-1:0] n_count;
    logic               w_hit;
    logic [2:0]         w_pos;
    logic [SumW-1:0]    w_start;

    // a set bit restarts the run, so bytes that are full drop out on their own
    always_comb begin
        n_count = r_count;
        w_hit   = 1'b0;
        w_pos   = '0;
        for (int i = 0; i < 8; i++) begin
            if (!w_hit) begin
                if (i_data[i]) begin
                    n_count = '0;
                end else begin
                    n_count = n_count + 1'b1;
                end
                if (n_count == i_len) begin
                    w_hit = 1'b1;
                    w_pos = 3'(i);
                end
            end
        end
    end

    assign w_start = SumW'({i_byte, w_pos}) + SumW'(1) - SumW'(i_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clr) begin
            r_count <= '0;
        end else if (i_ctl.en) begin
            r_count <= n_count;
        end
    end

    assign o_res.hit   = w_hit;
    assign o_res.start = w_start[BitIdxW-1:0];

endmodule
`default_nettype wire
